/* hdl/sr_pkg.sv */
// Shared types, constants and codes of the selective-repeat receiver.
`timescale 1ns / 1ps
package sr_pkg;

  // Storage dimensions.
  localparam int WINDOW_MAX  = 8;
  localparam int HANDLE_BITS = 16;
  localparam int POS_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // Field widths fixed by the frame format.
  localparam int SEQ_W   = 8;
  localparam int WS_W    = 4;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MAX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd2;

  // Status codes of a frame's status result.
  localparam logic [1:0] ST_ACKED   = 2'd0;
  localparam logic [1:0] ST_CRC_BAD = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_DONE    = 2'd3;

  // Result kinds.
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // One arrived frame.
  typedef struct packed {
    logic [SEQ_W-1:0]       seq_num;
    logic                   crc_ok;
    logic [HANDLE_BITS-1:0] payload_handle;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic                   result_kind;
    logic [1:0]             status;
    logic                   ack_valid;
    logic [SEQ_W-1:0]       ack_seq;
    logic [HANDLE_BITS-1:0] deliver_handle;
    logic [CNT_W-1:0]       delivered_count;
    logic [CNT_W-1:0]       error_count;
    logic                   done_res;
    logic                   last;
  } out_res_t;

  // Commands from the sequencer to the slot buffer.
  typedef struct packed {
    logic                   wr_en;
    logic [POS_W-1:0]       wr_pos;
    logic [HANDLE_BITS-1:0] wr_handle;
    logic                   shift;
  } slot_ctrl_t;

  // Head of the slot buffer as seen by the sequencer.
  typedef struct packed {
    logic                   head_valid;
    logic                   next_valid;
    logic [HANDLE_BITS-1:0] head_handle;
  } slot_stat_t;

endpackage

/* hdl/selective_repeat_receiver.sv */
// Top level of the selective-repeat receiver window with its sequencer.
`timescale 1ns / 1ps
// Receiver side of a selective-repeat link. Each request is one arrived frame;
// the block answers with a status result and then one delivery result for each
// filled slot released in order at the window head until the total is reached, the final one marked last.
// The frame is captured on acceptance and checked in the following state, and a
// good frame is then looked up by walking the window one position per cycle
// through a single shared step-and-compare unit. The status result is loaded
// after the check for a frame with a bad checksum or one that arrives after the
// transfer is done, and after the search for a good frame, which visits up to
// window_size positions (window_size clamped to 1..WINDOW_MAX); the deliveries
// follow, and a result waits while the result side stalls.
// A new frame is taken only once the previous frame's last result has
// been loaded into the output register. Configuration may be written only while
// the block is idle.
module selective_repeat_receiver (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sr_pkg::in_req_t          in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sr_pkg::out_res_t         out_res_o
);
  import sr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_STATUS = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [SEQ_W-1:0] seq_max_q;
  logic [WS_W-1:0]  win_size_q;
  logic [CNT_W-1:0] total_q;

  // Window state and counters.
  logic [SEQ_W-1:0] base_q, base_d;
  logic [CNT_W-1:0] delivered_q, delivered_d;
  logic [CNT_W-1:0] errors_q, errors_d;

  // Frame being worked on and the search walk.
  logic [SEQ_W-1:0]       seq_q;
  logic                   crc_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SEQ_W-1:0]       walk_q, walk_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [1:0]             st_q, st_d;

  // Output register.
  logic     out_valid_q;
  out_res_t out_q;
  out_res_t out_d;
  logic     out_load;
  logic     out_free;

  slot_ctrl_t slot_ctrl;
  slot_stat_t slot_stat;

  logic [SEQ_W-1:0] step_cur;
  logic [SEQ_W-1:0] step_next;
  logic             step_match;
  logic [POS_W-1:0] pos_last;
  logic             done;
  logic             drain_more;
  logic [CNT_W:0]   delivered_inc;

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_max_q  <= SEQ_W'(32);
      win_size_q <= WS_W'(8);
      total_q    <= CNT_W'(65535);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEQ_MAX:       seq_max_q  <= cfg_wdata_i[SEQ_W-1:0];
        REG_WINDOW_SIZE:   win_size_q <= cfg_wdata_i[WS_W-1:0];
        REG_TOTAL_PACKETS: total_q    <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Last window position to visit: size zero acts as one, oversize as full.
  always_comb begin
    if (win_size_q == '0) begin
      pos_last = '0;
    end else if (32'(win_size_q) > WINDOW_MAX) begin
      pos_last = POS_W'(WINDOW_MAX - 1);
    end else begin
      pos_last = POS_W'(win_size_q - WS_W'(1));
    end
  end

  assign done          = (delivered_q >= total_q);
  assign delivered_inc = {1'b0, delivered_q} + (CNT_W+1)'(1);
  assign drain_more    = slot_stat.next_valid && (delivered_inc < {1'b0, total_q});

  // The one step unit walks the window while searching and advances the base
  // while draining.
  assign step_cur = (state_q == S_DRAIN) ? base_q : walk_q;

  sr_step u_step (
    .cur_i     (step_cur),
    .seq_max_i (seq_max_q),
    .target_i  (seq_q),
    .next_o    (step_next),
    .match_o   (step_match)
  );

  sr_slots u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (slot_ctrl),
    .stat_o (slot_stat)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    delivered_d = delivered_q;
    errors_d    = errors_q;
    walk_d      = walk_q;
    pos_d       = pos_q;
    st_d        = st_q;
    out_load    = 1'b0;
    out_d       = out_q;

    slot_ctrl.wr_en     = 1'b0;
    slot_ctrl.wr_pos    = pos_q;
    slot_ctrl.wr_handle = handle_q;
    slot_ctrl.shift     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (done) begin
          st_d    = ST_DONE;
          state_d = S_STATUS;
        end else if (!crc_q) begin
          if (errors_q != '1) begin
            errors_d = errors_q + CNT_W'(1);
          end
          st_d    = ST_CRC_BAD;
          state_d = S_STATUS;
        end else begin
          walk_d  = base_q;
          pos_d   = '0;
          state_d = S_SEARCH;
        end
      end

      // One window position per cycle; the lowest match wins.
      S_SEARCH: begin
        if (step_match) begin
          slot_ctrl.wr_en = 1'b1;
          st_d            = ST_ACKED;
          state_d         = S_STATUS;
        end else if (pos_q == pos_last) begin
          st_d    = ST_OUTSIDE;
          state_d = S_STATUS;
        end else begin
          walk_d = step_next;
          pos_d  = pos_q + POS_W'(1);
        end
      end

      S_STATUS: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_d.result_kind     = KIND_STATUS;
          out_d.status          = st_q;
          out_d.ack_valid       = (st_q == ST_ACKED);
          out_d.ack_seq         = (st_q == ST_ACKED) ? seq_q : '0;
          out_d.deliver_handle  = '0;
          out_d.delivered_count = delivered_q;
          out_d.error_count     = errors_q;
          out_d.done_res        = done;
          if (slot_stat.head_valid && !done) begin
            out_d.last = 1'b0;
            state_d    = S_DRAIN;
          end else begin
            out_d.last = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end

      // Release the head slot, shift the window and advance the base.
      S_DRAIN: begin
        if (out_free) begin
          out_load              = 1'b1;
          slot_ctrl.shift       = 1'b1;
          delivered_d           = delivered_inc[CNT_W-1:0];
          base_d                = step_next;
          out_d.result_kind     = KIND_DELIVER;
          out_d.status          = ST_ACKED;
          out_d.ack_valid       = 1'b0;
          out_d.ack_seq         = '0;
          out_d.deliver_handle  = slot_stat.head_handle;
          out_d.delivered_count = delivered_inc[CNT_W-1:0];
          out_d.error_count     = errors_q;
          out_d.done_res        = (delivered_inc >= {1'b0, total_q});
          out_d.last            = !drain_more;
          if (!drain_more) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= SEQ_W'(1);
      delivered_q <= '0;
      errors_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      delivered_q <= delivered_d;
      errors_q    <= errors_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame capture, search walk and output payload.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      seq_q    <= in_req_i.seq_num;
      crc_q    <= in_req_i.crc_ok;
      handle_q <= in_req_i.payload_handle;
    end
    walk_q <= walk_d;
    pos_q  <= pos_d;
    st_q   <= st_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

/* hdl/sr_step.sv */
// Shared sequence-number step unit: wraparound increment and match compare.
`timescale 1ns / 1ps
module sr_step (
  input  logic [sr_pkg::SEQ_W-1:0] cur_i,
  input  logic [sr_pkg::SEQ_W-1:0] seq_max_i,
  input  logic [sr_pkg::SEQ_W-1:0] target_i,
  output logic [sr_pkg::SEQ_W-1:0] next_o,
  output logic                     match_o
);
  import sr_pkg::*;

  // Numbers run 1..seq_max and then wrap back to 1.
  assign next_o = (cur_i >= seq_max_i) ? SEQ_W'(1) : SEQ_W'(cur_i + SEQ_W'(1));

  // Number zero never matches a window position.
  assign match_o = (target_i != '0) && (cur_i == target_i);

endmodule

/* hdl/sr_slots.sv */
// Receive window slot buffer: valid bits and payload handles, shifting as a whole.
`timescale 1ns / 1ps
module sr_slots (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sr_pkg::slot_ctrl_t ctrl_i,
  output sr_pkg::slot_stat_t stat_o
);
  import sr_pkg::*;

  logic [WINDOW_MAX-1:0]  valid_q;
  logic [HANDLE_BITS-1:0] handle_q [WINDOW_MAX];

  // Valid bits are cleared at reset; a slot is filled at its position or the
  // whole row moves down by one on a delivery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_q >> 1;
    end else if (ctrl_i.wr_en) begin
      valid_q[ctrl_i.wr_pos] <= 1'b1;
    end
  end

  // Handles carry no reset; they are only used behind a set valid bit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int j = 0; j < WINDOW_MAX - 1; j++) begin
        handle_q[j] <= handle_q[j+1];
      end
      handle_q[WINDOW_MAX-1] <= '0;
    end else if (ctrl_i.wr_en) begin
      handle_q[ctrl_i.wr_pos] <= ctrl_i.wr_handle;
    end
  end

  // Head of the window for the delivery loop.
  always_comb begin
    stat_o.head_valid  = valid_q[0];
    stat_o.next_valid  = (WINDOW_MAX > 1) ? valid_q[(WINDOW_MAX > 1) ? 1 : 0] : 1'b0;
    stat_o.head_handle = handle_q[0];
  end

endmodule
